[hdl/fsa_pkg.sv]
// Shared types, codes and sizes for the frame stack allocator.
package fsa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 13;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);

    localparam logic [COUNT_W-1:0] MAX_FRAMES_C      = COUNT_W'(MAX_FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_MAX         = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] FRAME_TOTAL_RESET = COUNT_W'(4096);

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } fsa_func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ALREADY = 2'd1,
        STATUS_OOM     = 2'd2,
        STATUS_FULL    = 2'd3
    } fsa_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_POP
    } fsa_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_pop;
    } fsa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_needed;
    } fsa_stat_t;

endpackage

[hdl/fsa_ctrl.sv]
// Controller state machine: sequences capture, commit and stack pop of a request.
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  fsa_stat_t stat,
    output fsa_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    fsa_state_t state_reg, state_next;
    logic       done_reg, done_next;

    // Hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Advance through evaluate and optional pop
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_pop = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.commit = 1'b1;
                if (stat.pop_needed)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                cmd.load_pop = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[hdl/fsa_datapath.sv]
// Datapath: request latch, free stack memory, counters and result registers.
module fsa_datapath
    import fsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  fsa_cmd_t           cmd,
    output fsa_stat_t          stat,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               func,
    input  logic [FRAME_W-1:0] page_frame,
    input  logic               kernel_page,
    input  logic               writeable_page,
    output logic [FRAME_W-1:0] frame_out,
    output logic               present_bit,
    output logic               rw_bit,
    output logic               user_bit,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] allocated_count
);

    // Latched request
    logic               func_reg;
    logic [FRAME_W-1:0] page_frame_reg;
    logic               kernel_reg;
    logic               writeable_reg;

    // Allocator state
    logic [COUNT_W-1:0] frame_total_reg;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [COUNT_W-1:0] next_unused_reg, next_unused_next;
    logic [COUNT_W-1:0] in_use_reg, in_use_next;

    // Free stack memory
    logic [FRAME_W-1:0] mem [MAX_FRAMES];
    logic [FRAME_W-1:0] rd_data_reg;

    // Result registers
    logic [FRAME_W-1:0] frame_out_reg;
    logic               present_reg;
    logic               rw_reg;
    logic               user_reg;
    fsa_status_t        status_reg;

    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] fill_dec;
    logic [ADDR_W-1:0]  pop_addr;
    logic [ADDR_W-1:0]  push_addr;
    logic               is_alloc;
    logic               mapped;
    logic               pop_needed;
    logic               bump;
    logic               push;
    logic               got;
    fsa_status_t        res_status;
    logic [FRAME_W-1:0] res_frame;

    // Decode the latched request against current state
    assign cap       = (frame_total_reg > MAX_FRAMES_C) ? MAX_FRAMES_C : frame_total_reg;
    assign fill_dec  = fill_reg - 1'b1;
    assign pop_addr  = fill_dec[ADDR_W-1:0];
    assign push_addr = fill_reg[ADDR_W-1:0];
    assign is_alloc  = (func_reg == FUNC_ALLOC);
    assign mapped    = (page_frame_reg != '0);
    assign pop_needed = is_alloc && !mapped && (fill_reg != '0);
    assign bump      = is_alloc && !mapped && (fill_reg == '0) && (next_unused_reg < cap);
    assign push      = !is_alloc && (fill_reg < cap);
    assign got       = pop_needed || bump;

    assign stat.pop_needed = pop_needed;

    // Pick status and frame for the result
    always_comb
    begin
        res_status = STATUS_OK;
        res_frame  = '0;
        if (is_alloc)
        begin
            if (mapped)
            begin
                res_status = STATUS_ALREADY;
                res_frame  = page_frame_reg;
            end
            else if (bump)
            begin
                res_frame = FRAME_W'(next_unused_reg);
            end
            else if (!pop_needed)
            begin
                res_status = STATUS_OOM;
            end
        end
        else if (!push)
        begin
            res_status = STATUS_FULL;
        end
    end

    // Compute counter updates on commit
    always_comb
    begin
        fill_next        = fill_reg;
        next_unused_next = next_unused_reg;
        in_use_next      = in_use_reg;
        if (cmd.commit)
        begin
            if (pop_needed)
            begin
                fill_next = fill_dec;
            end
            if (push)
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (bump)
            begin
                next_unused_next = next_unused_reg + 1'b1;
            end
            if (got && (in_use_reg != COUNT_MAX))
            begin
                in_use_next = in_use_reg + 1'b1;
            end
            if (push && (in_use_reg != '0))
            begin
                in_use_next = in_use_reg - 1'b1;
            end
        end
    end

    // Hold configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_total_reg <= FRAME_TOTAL_RESET;
            fill_reg        <= '0;
            next_unused_reg <= '0;
            in_use_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frame_total_reg <= cfg_wr_data;
            end
            fill_reg        <= fill_next;
            next_unused_reg <= next_unused_next;
            in_use_reg      <= in_use_next;
        end
    end

    // Latch the request at acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg       <= func;
            page_frame_reg <= page_frame;
            kernel_reg     <= kernel_page;
            writeable_reg  <= writeable_page;
        end
    end

    // Push on free, registered read on pop
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
        begin
            mem[push_addr] <= page_frame_reg;
        end
        if (cmd.commit && pop_needed)
        begin
            rd_data_reg <= mem[pop_addr];
        end
    end

    // Load the result, frame from the stack after a pop
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            frame_out_reg <= res_frame;
            status_reg    <= res_status;
            present_reg   <= got;
            rw_reg        <= got & writeable_reg;
            user_reg      <= got & ~kernel_reg;
        end
        if (cmd.load_pop)
        begin
            frame_out_reg <= rd_data_reg;
        end
    end

    assign frame_out       = frame_out_reg;
    assign present_bit     = present_reg;
    assign rw_bit          = rw_reg;
    assign user_bit        = user_reg;
    assign status          = status_reg;
    assign allocated_count = in_use_reg;

endmodule

[hdl/frame_stack_allocator.sv]
// Top level of the physical page frame allocator.
//
// Usage:
//   Requests enter on start while busy is low, with func (0 allocate,
//   1 free), page_frame, kernel_page and writeable_page. The request is
//   accepted at that edge and busy rises at once.
//   Each request gives one result, shown for a single cycle with done high:
//   frame_out, present_bit, rw_bit, user_bit, status and allocated_count.
//   The receiver cannot stall; it must take the result in that cycle.
//   Order: the accepting edge latches the request and enters evaluate,
//   whose end loads the result registers and done; an allocate that pops
//   the free stack registers the stack memory read in evaluate, and the pop
//   state then loads that frame into frame_out and raises done. The
//   controller runs one request at a time through evaluate and pop states.
//   frame_total is written through cfg_wr_en / cfg_wr_data; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Reset: rst_n clears the stack fill, bump pointer and allocated count,
//   sets frame_total to 4096 and returns the controller to idle. Stack
//   memory contents are not cleared; only pushed entries are ever read.
module frame_stack_allocator
    import fsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               func,
    input  logic [FRAME_W-1:0] page_frame,
    input  logic               kernel_page,
    input  logic               writeable_page,
    output logic               done,
    output logic [FRAME_W-1:0] frame_out,
    output logic               present_bit,
    output logic               rw_bit,
    output logic               user_bit,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] allocated_count
);

    fsa_cmd_t  cmd;
    fsa_stat_t stat;

    fsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fsa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .func            (func),
        .page_frame      (page_frame),
        .kernel_page     (kernel_page),
        .writeable_page  (writeable_page),
        .frame_out       (frame_out),
        .present_bit     (present_bit),
        .rw_bit          (rw_bit),
        .user_bit        (user_bit),
        .status          (status),
        .allocated_count (allocated_count)
    );

endmodule

[hdl/fsa_checker.sv]
// Port-level checker for the frame stack allocator, bound to the top level.
module fsa_checker
    import fsa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               present_bit,
    input logic               rw_bit,
    input logic               user_bit,
    input logic [1:0]         status,
    input logic [COUNT_W-1:0] allocated_count
);

    // Accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Failed or already-mapped requests carry no page flags
    a_flags_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (!present_bit && !rw_bit && !user_bit))
        else $error("page flags set on a non-ok result");

    // A granted frame is counted as allocated
    a_count_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && present_bit) |-> (allocated_count != '0))
        else $error("allocated count zero after a grant");

endmodule

bind frame_stack_allocator fsa_checker u_fsa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .present_bit     (present_bit),
    .rw_bit          (rw_bit),
    .user_bit        (user_bit),
    .status          (status),
    .allocated_count (allocated_count)
);

[test/frame_stack_allocator_tb.sv]
// Self-checking testbench for the frame stack allocator: directed, saturation and random requests.
`timescale 1ns / 100ps

module frame_stack_allocator_tb;
    import fsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int END_SETTLE     = 12;
    localparam int PHASE_ITEMS    = 40;

    typedef struct packed {
        fsa_func_t          func;
        logic [FRAME_W-1:0] frame;
        logic               kern;
        logic               wr;
    } alloc_request_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               rw;
        logic               user;
        fsa_status_t        status;
        logic [COUNT_W-1:0] count;
    } alloc_result_t;

    // Frame allocator predictor plus the queue of results it owes
    class frame_scoreboard;
        bit [FRAME_W-1:0] stacked [MAX_FRAMES];
        bit [COUNT_W-1:0] fill;
        bit [COUNT_W-1:0] bump;
        bit [COUNT_W-1:0] in_use;
        bit [COUNT_W-1:0] frame_total;
        alloc_result_t    pending [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      status_hits [4];
        int unsigned      peak_count;

        function new();
            fill        = '0;
            bump        = '0;
            in_use      = '0;
            frame_total = FRAME_TOTAL_RESET;
            mismatches  = 0;
            checked     = 0;
            peak_count  = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function bit [COUNT_W-1:0] capacity();
            return (frame_total > MAX_FRAMES_C) ? MAX_FRAMES_C : frame_total;
        endfunction

        function void set_total(bit [COUNT_W-1:0] value);
            frame_total = value;
        endfunction

        // Advance the allocator state for one accepted request and queue its result
        function void note_request(alloc_request_t req);
            alloc_result_t    res;
            bit [COUNT_W-1:0] cap;
            cap        = capacity();
            res        = '0;
            res.status = STATUS_OK;
            if (req.func == FUNC_ALLOC) begin
                if (req.frame != '0) begin
                    // page already mapped: echo its frame, touch nothing
                    res.status = STATUS_ALREADY;
                    res.frame  = req.frame;
                end else if (fill != '0 || bump < cap) begin
                    if (fill != '0) begin
                        fill      = fill - 1'b1;
                        res.frame = stacked[fill[ADDR_W-1:0]];
                    end else begin
                        res.frame = FRAME_W'(bump);
                        bump      = bump + 1'b1;
                    end
                    if (in_use != COUNT_MAX)
                        in_use = in_use + 1'b1;
                    res.present = 1'b1;
                    res.rw      = req.wr;
                    res.user    = ~req.kern;
                end else begin
                    res.status = STATUS_OOM;
                end
            end else if (fill >= cap) begin
                res.status = STATUS_FULL;
            end else begin
                stacked[fill[ADDR_W-1:0]] = req.frame;
                fill = fill + 1'b1;
                if (in_use != '0)
                    in_use = in_use - 1'b1;
            end
            res.count = in_use;
            status_hits[res.status]++;
            if (in_use > peak_count)
                peak_count = in_use;
            pending.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [FRAME_W-1:0] got, logic [FRAME_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h (result %0d)",
                                          name, got, want, checked));
        endtask

        // Compare one result against the oldest outstanding request
        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result: frame %h status %0d",
                                          got.frame, got.status));
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("frame_out", got.frame, want.frame);
            check_field("present_bit", FRAME_W'(got.present), FRAME_W'(want.present));
            check_field("rw_bit", FRAME_W'(got.rw), FRAME_W'(want.rw));
            check_field("user_bit", FRAME_W'(got.user), FRAME_W'(want.user));
            check_field("status", FRAME_W'(got.status), FRAME_W'(want.status));
            check_field("allocated_count", FRAME_W'(got.count), FRAME_W'(want.count));
        endtask

        task flush_leftovers();
            while (pending.size() != 0) begin
                report_mismatch($sformatf("no result for request with expected status %0d",
                                          pending[0].status));
                void'(pending.pop_front());
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               func;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_page;
    logic               writeable_page;
    logic               done;
    logic [FRAME_W-1:0] frame_out;
    logic               present_bit;
    logic               rw_bit;
    logic               user_bit;
    logic [1:0]         status;
    logic [COUNT_W-1:0] allocated_count;

    frame_scoreboard sb = new();
    alloc_result_t   seen_result;
    int unsigned     total_settings;
    int unsigned     quiet_cycles;

    frame_stack_allocator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .func            (func),
        .page_frame      (page_frame),
        .kernel_page     (kernel_page),
        .writeable_page  (writeable_page),
        .done            (done),
        .frame_out       (frame_out),
        .present_bit     (present_bit),
        .rw_bit          (rw_bit),
        .user_bit        (user_bit),
        .status          (status),
        .allocated_count (allocated_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every strobed result at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1) begin
            seen_result = {frame_out, present_bit, rw_bit, user_bit,
                           fsa_status_t'(status), allocated_count};
            sb.check_result(seen_result);
        end
    end

    // Drop the run when neither a request nor a result moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [FRAME_W-1:0] random_frame();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return FRAME_W'($urandom);
        endcase
    endfunction

    // Present one request after an optional idle gap and hold it until accepted
    task automatic send_request(input fsa_func_t f, input logic [FRAME_W-1:0] pf,
                                input logic k, input logic w, input int gap);
        alloc_request_t req;
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start          <= 1'b1;
        func           <= f;
        page_frame     <= pf;
        kernel_page    <= k;
        writeable_page <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        req = '{f, pf, k, w};
        sb.note_request(req);
    endtask

    // Hold off new requests until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_frame_total(input bit [COUNT_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.set_total(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        total_settings++;
    endtask

    // Hand-picked requests: every status, field extremes, frame zero, shrunk total
    task automatic run_directed();
        write_frame_total('0);
        send_request(FUNC_ALLOC, '0, 1'b0, 1'b0, $urandom_range(0, 6));
        send_request(FUNC_FREE, 20'h00001, 1'b1, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, '1, 1'b1, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, 20'h00001, 1'b0, 1'b1, $urandom_range(0, 6));

        // free at zero count keeps the count at zero
        write_frame_total(13'd3);
        send_request(FUNC_FREE, '1, 1'b0, 1'b0, $urandom_range(0, 6));
        send_request(FUNC_FREE, '0, 1'b1, 1'b0, $urandom_range(0, 6));
        send_request(FUNC_FREE, 20'h5A5A5, 1'b0, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_FREE, 20'h12345, 1'b1, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, '0, 1'b1, 1'b0, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, '0, 1'b0, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_FREE, 20'hA5A5A, 1'b0, 1'b0, $urandom_range(0, 6));

        // capacity below the stack fill: pops still work, pushes refused
        write_frame_total(13'd1);
        send_request(FUNC_FREE, 20'h0F0F0, 1'b1, 1'b0, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, '0, 1'b1, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_FREE, 20'h33333, 1'b0, 1'b1, $urandom_range(0, 6));
        send_request(FUNC_ALLOC, '0, 1'b0, 1'b0, 0);
        send_request(FUNC_FREE, 20'h7FFFF, 1'b1, 1'b1, 0);
        send_request(FUNC_ALLOC, 20'h80000, 1'b1, 1'b0, 0);
    endtask

    // Fill a small stack at zero count, then pop it and walk the bump pointer to the end,
    // which runs the allocator out of memory with the count above the frame total
    task automatic run_saturation();
        int unsigned allocs;
        write_frame_total(13'd64);
        while (sb.fill < sb.capacity())
            send_request(FUNC_FREE, random_frame(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 0);
        allocs = sb.fill + (sb.capacity() - sb.bump) + 1;
        repeat (allocs)
            send_request(FUNC_ALLOC, '0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 0);
        repeat (3)
            send_request(FUNC_FREE, random_frame(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom_range(0, 6));
    endtask

    task automatic run_random_phase(input bit [COUNT_W-1:0] total, input int items);
        int                 free_pct;
        bit                 burst;
        int                 gap;
        fsa_func_t          f;
        logic [FRAME_W-1:0] pf;
        write_frame_total(total);
        free_pct = $urandom_range(25, 75);
        burst    = 1'b0;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 29) == 0)
                burst = ~burst;
            if ($urandom_range(0, 24) == 0)
                drain_results();
            gap = burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 99) < free_pct) begin
                f  = FUNC_FREE;
                pf = random_frame();
            end else begin
                f  = FUNC_ALLOC;
                pf = ($urandom_range(0, 3) == 0) ? random_frame() : '0;
            end
            send_request(f, pf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        func           = FUNC_ALLOC;
        page_frame     = '0;
        kernel_page    = 1'b0;
        writeable_page = 1'b0;
        total_settings = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_saturation();
        run_random_phase(13'd4096, PHASE_ITEMS);
        run_random_phase('1, PHASE_ITEMS);
        run_random_phase('0, PHASE_ITEMS);
        run_random_phase(13'd2, PHASE_ITEMS);
        run_random_phase(13'd16, PHASE_ITEMS);
        run_random_phase(13'd4095, PHASE_ITEMS);
        run_random_phase(COUNT_W'($urandom_range(0, 8191)), PHASE_ITEMS);
        run_random_phase(13'd1, PHASE_ITEMS);
        run_random_phase(13'd300, PHASE_ITEMS);
        run_random_phase(13'd64, PHASE_ITEMS);

        // settle, then flag anything still owed
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        sb.flush_leftovers();

        $display("Covered %0d results over %0d frame_total settings",
                 sb.checked, total_settings);
        $display("ok %0d, mapped %0d, oom %0d, full %0d, peak count %0d, mismatches %0d",
                 sb.status_hits[STATUS_OK], sb.status_hits[STATUS_ALREADY],
                 sb.status_hits[STATUS_OOM], sb.status_hits[STATUS_FULL],
                 sb.peak_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[frame_stack_allocator.f]
hdl/fsa_pkg.sv
hdl/fsa_ctrl.sv
hdl/fsa_datapath.sv
hdl/frame_stack_allocator.sv
hdl/fsa_checker.sv
test/frame_stack_allocator_tb.sv
